// ===== hw/rtl/cdq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and constants for the circular deque block.
// ----------------------------------------------------------------------------
package cdq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int DATA_W    = 32;
    localparam int FUNC_W    = 2;
    localparam int STATUS_W  = 2;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH_FRONT = 2'd0,
        FN_PUSH_BACK  = 2'd1,
        FN_POP_FRONT  = 2'd2
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DONE
    } t_state;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic exec;
    } t_dp_cmd;

endpackage

// ===== hw/rtl/circular_deque.sv =====
`timescale 1ns / 1ps
// A request is captured on acceptance, executed with the registered store
// read, then its result is held in S_DONE until taken; no new request is
// accepted before then, so a stalled result holds the block.
// Reset: head, tail and count clear and the block is ready as soon as reset
// is released; the entry store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// circular_deque
// Fixed-depth double-ended queue: push front, push back, pop front.
// ----------------------------------------------------------------------------
module circular_deque
    import cdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [FUNC_W-1:0]   i_func,
    input  logic [DATA_W-1:0]   i_data_in,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic [DATA_W-1:0]   o_data_out,
    output logic [CNT_W-1:0]    o_occupancy,
    output logic                o_is_full,
    output logic                o_is_empty
);

    t_dp_cmd cmd;

    cdq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .o_cmd       (cmd)
    );

    cdq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_func      (i_func),
        .i_data_in   (i_data_in),
        .o_status    (o_status),
        .o_data_out  (o_data_out),
        .o_occupancy (o_occupancy),
        .o_is_full   (o_is_full),
        .o_is_empty  (o_is_empty)
    );

endmodule

// ===== hw/rtl/cdq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_ctrl
// Request sequencer: capture, execute, then hold the result until taken.
// ----------------------------------------------------------------------------
module cdq_ctrl
    import cdq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                // no request is taken while reset is held
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/cdq_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_dp
// Deque datapath: entry store, head and tail indices, count and result.
// ----------------------------------------------------------------------------
module cdq_dp
    import cdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    localparam int IDX_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    input  logic [FUNC_W-1:0]   i_func,
    input  logic [DATA_W-1:0]   i_data_in,
    output logic [STATUS_W-1:0] o_status,
    output logic [DATA_W-1:0]   o_data_out,
    output logic [CNT_W-1:0]    o_occupancy,
    output logic                o_is_full,
    output logic                o_is_empty
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [DATA_W-1:0]   r_mem [DEPTH];
    logic [FUNC_W-1:0]   r_func;
    logic [DATA_W-1:0]   r_data;
    logic [IDX_W-1:0]    r_head;
    logic [IDX_W-1:0]    r_tail;
    logic [CNT_W-1:0]    r_count;
    logic [STATUS_W-1:0] r_status;
    logic                r_pop_ok;
    logic [DATA_W-1:0]   r_rd_data;

    logic [IDX_W-1:0]    n_head;
    logic [IDX_W-1:0]    n_tail;
    logic [CNT_W-1:0]    n_count;
    logic [STATUS_W-1:0] n_status;
    logic                n_pop_ok;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [IDX_W-1:0]    head_inc;
    logic [IDX_W-1:0]    head_dec;
    logic [IDX_W-1:0]    tail_inc;
    logic                full;
    logic                empty;

    assign full     = (r_count == FULL_CNT);
    assign empty    = (r_count == '0);
    assign head_inc = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
    assign head_dec = (r_head == '0) ? LAST_IDX : r_head - 1'b1;
    assign tail_inc = (r_tail == LAST_IDX) ? '0 : r_tail + 1'b1;

    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_count  = r_count;
        n_status = ST_DONE;
        n_pop_ok = 1'b0;
        wr_en    = 1'b0;
        wr_addr  = r_tail;
        case (r_func)
            FN_PUSH_FRONT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_head  = head_dec;
                    wr_en   = 1'b1;
                    wr_addr = head_dec;
                    n_count = r_count + 1'b1;
                end
            end
            FN_PUSH_BACK: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_tail  = tail_inc;
                    wr_en   = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            FN_POP_FRONT: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_pop_ok = 1'b1;
                    n_head   = head_inc;
                    n_count  = r_count - 1'b1;
                end
            end
            default: begin
                // unused request code leaves store, indices and count as they are
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_data <= i_data_in;
        end
        if (i_cmd.exec) begin
            r_status <= n_status;
            r_pop_ok <= n_pop_ok;
        end
    end

    // entry store: one write port, one registered read at the front
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && wr_en) begin
            r_mem[wr_addr] <= r_data;
        end
        if (i_cmd.exec) begin
            r_rd_data <= r_mem[r_head];
        end
    end

    assign o_status    = r_status;
    assign o_data_out  = r_pop_ok ? r_rd_data : '0;
    assign o_occupancy = r_count;
    assign o_is_full   = full;
    assign o_is_empty  = empty;

endmodule

// ===== hw/rtl/cdq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_checker
// Port-level checks for the circular deque, bound to the top level.
// ----------------------------------------------------------------------------
module cdq_checker
    import cdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_ready,
    input logic                o_valid,
    input logic                i_ready,
    input logic [STATUS_W-1:0] o_status,
    input logic [DATA_W-1:0]   o_data_out,
    input logic [CNT_W-1:0]    o_occupancy,
    input logic                o_is_full,
    input logic                o_is_empty
);

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    // a stalled result keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_data_out)
            && $stable(o_occupancy))
        else $error("result changed while stalled");

    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_is_empty == (o_occupancy == '0))
            && (o_is_full == (o_occupancy == FULL_CNT)))
        else $error("flags disagree with occupancy");

    // a refused request returns zero data
    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_DONE) |-> o_data_out == '0)
        else $error("refused request returned data");

    a_full_refuse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_FULL) |-> o_is_full)
        else $error("full refusal while not full");

    // one request in flight at a time
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready ##1 !o_ready)
        else $error("request accepted while another is in flight");

endmodule

bind circular_deque cdq_checker #(
    .DEPTH (DEPTH)
) u_cdq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_status    (o_status),
    .o_data_out  (o_data_out),
    .o_occupancy (o_occupancy),
    .o_is_full   (o_is_full),
    .o_is_empty  (o_is_empty)
);

// ===== dv/circular_deque_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_deque_tb
// Self-checking bench for the circular deque. A short table of push and pop
// requests covers the empty and full corners, then biased random requests
// fill and drain the store under random backpressure. Every result is
// checked, against the table where it gives one, else a behavioral deque.
// ----------------------------------------------------------------------------
module circular_deque_tb;
    import cdq_pkg::*;

    localparam int DQ_DEPTH      = DEPTH_DEF;
    localparam int CNT_W         = $clog2(DQ_DEPTH + 1);
    localparam int RAND_ITEMS    = 1400;
    localparam int HOLD_CYCLES   = 80;
    localparam int SETTLE_CYCLES = 8;

    // request code with no operation behind it
    localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   data_out;
        logic [CNT_W-1:0]    occupancy;
        logic                is_full;
        logic                is_empty;
    } t_deque_result;

    typedef struct {
        logic [FUNC_W-1:0] fn;
        logic [DATA_W-1:0] val;
        bit                typed;
        t_deque_result     exp;
    } t_request_row;

    localparam t_deque_result NO_CHECK = '{ST_DONE, '0, '0, 1'b0, 1'b0};

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic [FUNC_W-1:0]   i_func;
    logic [DATA_W-1:0]   i_data_in;
    logic                o_valid;
    logic                i_ready;
    logic [STATUS_W-1:0] o_status;
    logic [DATA_W-1:0]   o_data_out;
    logic [CNT_W-1:0]    o_occupancy;
    logic                o_is_full;
    logic                o_is_empty;

    // behavioral deque
    logic [DATA_W-1:0] deque_mem [DQ_DEPTH];
    int unsigned       deque_head;
    int unsigned       deque_tail;
    int unsigned       deque_count;

    t_deque_result pending_results [$];
    int            fail_count    = 0;
    int            send_idle_pct = 32;
    int            rcv_idle_pct  = 80;
    bit            rcv_hold_req  = 1'b0;

    circular_deque #(
        .DEPTH(DQ_DEPTH)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_func     (i_func),
        .i_data_in  (i_data_in),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_status   (o_status),
        .o_data_out (o_data_out),
        .o_occupancy(o_occupancy),
        .o_is_full  (o_is_full),
        .o_is_empty (o_is_empty)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_deque_result deque_step(input logic [FUNC_W-1:0] fn,
                                                 input logic [DATA_W-1:0] val);
        t_deque_result r;
        r.status   = ST_DONE;
        r.data_out = '0;
        case (fn)
            FN_PUSH_FRONT: begin
                if (deque_count == DQ_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    deque_head = (deque_head == 0) ? DQ_DEPTH - 1 : deque_head - 1;
                    deque_mem[deque_head] = val;
                    deque_count++;
                end
            end
            FN_PUSH_BACK: begin
                if (deque_count == DQ_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    deque_mem[deque_tail] = val;
                    deque_tail = (deque_tail == DQ_DEPTH - 1) ? 0 : deque_tail + 1;
                    deque_count++;
                end
            end
            FN_POP_FRONT: begin
                if (deque_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.data_out = deque_mem[deque_head];
                    deque_head = (deque_head == DQ_DEPTH - 1) ? 0 : deque_head + 1;
                    deque_count--;
                end
            end
            default: begin
            end
        endcase
        r.occupancy = CNT_W'(deque_count);
        r.is_full   = (deque_count == DQ_DEPTH);
        r.is_empty  = (deque_count == 0);
        return r;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_request(input logic [FUNC_W-1:0] fn, input logic [DATA_W-1:0] val,
                                input bit typed, input t_deque_result exp);
        t_deque_result got;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_func    <= fn;
        i_data_in <= val;
        do @(posedge i_clk); while (!o_ready);
        got = deque_step(fn, val);
        pending_results.push_back(typed ? exp : got);
        @(negedge i_clk);
    endtask

    initial begin
        i_ready = 1'b0;
        @(negedge i_clk);
        forever begin
            if (rcv_hold_req) begin
                // long stall so the block backs up into the request side
                rcv_hold_req = 1'b0;
                i_ready <= 1'b0;
                for (int c = 0; c < HOLD_CYCLES; c++) @(negedge i_clk);
            end else begin
                i_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
                @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_deque_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: status %0d data_out %h occupancy %0d",
                       o_status, o_data_out, o_occupancy);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    fail_count++;
                end
                if (o_data_out !== want.data_out) begin
                    $error("data_out: expected %h, got %h", want.data_out, o_data_out);
                    fail_count++;
                end
                if (o_occupancy !== want.occupancy) begin
                    $error("occupancy: expected %0d, got %0d", want.occupancy, o_occupancy);
                    fail_count++;
                end
                if (o_is_full !== want.is_full) begin
                    $error("is_full: expected %0d, got %0d", want.is_full, o_is_full);
                    fail_count++;
                end
                if (o_is_empty !== want.is_empty) begin
                    $error("is_empty: expected %0d, got %0d", want.is_empty, o_is_empty);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        t_request_row      dir_rows [$];
        int                seg_left;
        int                seg_mode;
        int                pick;
        logic [FUNC_W-1:0] fn;
        logic [DATA_W-1:0] val;

        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_func      = '0;
        i_data_in   = '0;
        deque_head  = 0;
        deque_tail  = 0;
        deque_count = 0;
        seg_left    = 0;
        seg_mode    = 0;

        // corners: empty pop, unused code, extremes through both ends, wrap and full
        dir_rows.push_back('{FN_POP_FRONT, 32'h0, 1'b1,
                             '{ST_EMPTY, 32'h0, CNT_W'(0), 1'b0, 1'b1}});
        dir_rows.push_back('{FN_UNUSED, 32'hFFFF_FFFF, 1'b1,
                             '{ST_DONE, 32'h0, CNT_W'(0), 1'b0, 1'b1}});
        dir_rows.push_back('{FN_PUSH_FRONT, 32'h7FFF_FFFF, 1'b1,
                             '{ST_DONE, 32'h0, CNT_W'(1), 1'b0, 1'b0}});
        dir_rows.push_back('{FN_PUSH_BACK, 32'h8000_0000, 1'b1,
                             '{ST_DONE, 32'h0, CNT_W'(2), 1'b0, 1'b0}});
        dir_rows.push_back('{FN_POP_FRONT, 32'hFFFF_FFFF, 1'b1,
                             '{ST_DONE, 32'h7FFF_FFFF, CNT_W'(1), 1'b0, 1'b0}});
        dir_rows.push_back('{FN_POP_FRONT, 32'h0, 1'b1,
                             '{ST_DONE, 32'h8000_0000, CNT_W'(0), 1'b0, 1'b1}});
        dir_rows.push_back('{FN_POP_FRONT, 32'h0, 1'b1,
                             '{ST_EMPTY, 32'h0, CNT_W'(0), 1'b0, 1'b1}});
        dir_rows.push_back('{FN_PUSH_BACK, 32'hFFFF_FFFF, 1'b0, NO_CHECK});
        dir_rows.push_back('{FN_PUSH_FRONT, 32'h0, 1'b0, NO_CHECK});
        for (int k = 0; k < DQ_DEPTH - 2; k++) begin
            dir_rows.push_back('{FN_PUSH_BACK, $urandom(), 1'b0, NO_CHECK});
        end
        dir_rows.push_back('{FN_PUSH_FRONT, 32'h1234_5678, 1'b1,
                             '{ST_FULL, 32'h0, CNT_W'(DQ_DEPTH), 1'b1, 1'b0}});
        dir_rows.push_back('{FN_PUSH_BACK, 32'h8765_4321, 1'b1,
                             '{ST_FULL, 32'h0, CNT_W'(DQ_DEPTH), 1'b1, 1'b0}});

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            send_request(dir_rows[i].fn, dir_rows[i].val, dir_rows[i].typed, dir_rows[i].exp);
        end

        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n == RAND_ITEMS / 3 || n == 2 * RAND_ITEMS / 3) begin
                // stop offering until the block has handed back everything
                i_valid <= 1'b0;
                while (pending_results.size() != 0) @(posedge i_clk);
                @(negedge i_clk);
                if (n == RAND_ITEMS / 3) begin
                    send_idle_pct = 80;
                    rcv_idle_pct  = 32;
                end else begin
                    send_idle_pct = 0;
                    rcv_idle_pct  = 0;
                    rcv_hold_req  = 1'b1;
                end
            end
            // segments lean toward filling, draining, or an even mix
            if (seg_left == 0) begin
                seg_mode = $urandom_range(0, 2);
                seg_left = $urandom_range(8, 40);
            end
            seg_left--;
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                fn = FN_UNUSED;
            end else if ((seg_mode == 0 && pick < 78) || (seg_mode == 1 && pick >= 78) ||
                         (seg_mode == 2 && pick < 52)) begin
                fn = $urandom_range(0, 1) ? FN_PUSH_FRONT : FN_PUSH_BACK;
            end else begin
                fn = FN_POP_FRONT;
            end
            case ($urandom_range(0, 9))
                0:       val = 32'h7FFF_FFFF;
                1:       val = 32'h8000_0000;
                2:       val = '0;
                3:       val = '1;
                default: val = $urandom();
            endcase
            send_request(fn, val, 1'b0, NO_CHECK);
        end

        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #(2_000_000);
        $display("tb: failure");
        $finish;
    end

endmodule
